// ===== sv/mspid_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mspid_pkg
// Types, widths and constants shared by the motor speed PID step block.
// ----------------------------------------------------------------------------
package mspid_pkg;

  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned GAIN_W   = 24;
  localparam int unsigned BOUND_W  = 31;
  localparam int unsigned ESIGN_W  = 2;
  localparam int unsigned PWM_W    = 16;
  localparam int unsigned MAG_W    = 17;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned REG_IW   = 3;

  // shared multiplier: signed A x signed B
  localparam int unsigned MUL_AW   = 34;
  localparam int unsigned MUL_BW   = 25;
  localparam int unsigned MUL_PW   = MUL_AW + MUL_BW;
  localparam int unsigned ACC_W    = MUL_PW + 1;

  // constant-divisor divider, DIV_STEP quotient bits per cycle
  localparam int unsigned DIV_NW    = 44;
  localparam int unsigned DIV_DW    = 10;
  localparam int unsigned DIV_STEP  = 4;
  localparam int unsigned DIV_CYC   = DIV_NW / DIV_STEP;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_CYC + 1);

  localparam int unsigned MS_PER_S = 1000;
  localparam logic [PWM_W-1:0] PWM_MIN = PWM_W'(10);
  localparam logic [MAG_W-1:0] MAG_ONE = MAG_W'(1) << 16;
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [GAIN_W-1:0]  RST_GAIN   = '0;
  localparam logic [BOUND_W-1:0] RST_BOUND  = BOUND_W'(65536);
  localparam logic [GAIN_W-1:0]  RST_CTS    = GAIN_W'(65536);
  localparam logic [ESIGN_W-1:0] RST_ESIGN  = ESIGN_W'(1);
  localparam logic               RST_POL    = 1'b1;
  localparam logic [PWM_W-1:0]   RST_PERIOD = PWM_W'(1000);

  typedef enum logic [REG_IW-1:0] {
    REG_GAIN_P   = 3'd0,
    REG_GAIN_I   = 3'd1,
    REG_GAIN_D   = 3'd2,
    REG_BOUND    = 3'd3,
    REG_CTS      = 3'd4,
    REG_ESIGN    = 3'd5,
    REG_POLARITY = 3'd6,
    REG_PERIOD   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [BOUND_W-1:0] bound;
    logic [GAIN_W-1:0]  cts;
    logic [ESIGN_W-1:0] esign;
    logic               polarity;
    logic [PWM_W-1:0]   period;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_MEAS_MUL,
    ST_MEAS,
    ST_ERROR,
    ST_INC_MUL,
    ST_INC_DIV,
    ST_INC_WAIT,
    ST_INTEG,
    ST_DIF_MUL,
    ST_DIF_DIV,
    ST_DIF_WAIT,
    ST_DERIV,
    ST_GAIN_P,
    ST_GAIN_I,
    ST_GAIN_D,
    ST_SUM,
    ST_CLAMP,
    ST_PWM,
    ST_FIN
  } state_e;

endpackage
`default_nettype wire

// ===== sv/mspid_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mspid_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mspid_mul (
  input  wire logic                                  clk_i,
  input  wire logic signed [mspid_pkg::MUL_AW-1:0]   a_i,
  input  wire logic signed [mspid_pkg::MUL_BW-1:0]   b_i,
  output      logic signed [mspid_pkg::MUL_PW-1:0]   prod_o
);
  import mspid_pkg::*;

  logic signed [MUL_PW-1:0] prod_d;
  logic signed [MUL_PW-1:0] prod_q;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule
`default_nettype wire

// ===== sv/mspid_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mspid_div
// Unsigned restoring divider for narrow divisors, several quotient bits
// per cycle.
// ----------------------------------------------------------------------------
module mspid_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mspid_pkg::div_req_t           req_i,
  output      logic                          busy_o,
  output      logic [mspid_pkg::DIV_NW-1:0]  quot_o
);
  import mspid_pkg::*;

  logic                 busy_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NW-1:0]    x_q;
  logic [DIV_DW-1:0]    rem_q;
  logic [DIV_DW-1:0]    den_q;

  logic [DIV_NW-1:0]    x_w;
  logic [DIV_DW-1:0]    r_w;
  logic [DIV_DW:0]      r_ext;

  always_comb begin
    x_w   = x_q;
    r_w   = rem_q;
    r_ext = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      r_ext = {r_w, x_w[DIV_NW-1]};
      x_w   = {x_w[DIV_NW-2:0], 1'b0};
      if (r_ext >= {1'b0, den_q}) begin
        r_ext  = r_ext - {1'b0, den_q};
        x_w[0] = 1'b1;
      end
      r_w = r_ext[DIV_DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_CNT_W'(DIV_CYC);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= req_i.dividend;
      rem_q <= '0;
      den_q <= req_i.divisor;
    end else if (busy_q) begin
      x_q   <= x_w;
      rem_q <= r_w;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = x_q;

endmodule
`default_nettype wire

// ===== sv/mspid_regs.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mspid_regs
// APB configuration register file: gains, clamp, scaling, encoder sign, polarity and PWM period.
// ----------------------------------------------------------------------------
module mspid_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mspid_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mspid_pkg::APB_DW-1:0]   pwdata,
  output      logic [mspid_pkg::APB_DW-1:0]   prdata,
  output      logic                           pready,
  output      mspid_pkg::cfg_t                cfg_o
);
  import mspid_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p   <= RST_GAIN;
      cfg_q.gain_i   <= RST_GAIN;
      cfg_q.gain_d   <= RST_GAIN;
      cfg_q.bound    <= RST_BOUND;
      cfg_q.cts      <= RST_CTS;
      cfg_q.esign    <= RST_ESIGN;
      cfg_q.polarity <= RST_POL;
      cfg_q.period   <= RST_PERIOD;
    end else if (wr_en) begin
      case (idx)
        REG_GAIN_P:   cfg_q.gain_p   <= pwdata[GAIN_W-1:0];
        REG_GAIN_I:   cfg_q.gain_i   <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:   cfg_q.gain_d   <= pwdata[GAIN_W-1:0];
        REG_BOUND:    cfg_q.bound    <= pwdata[BOUND_W-1:0];
        REG_CTS:      cfg_q.cts      <= pwdata[GAIN_W-1:0];
        REG_ESIGN:    cfg_q.esign    <= pwdata[ESIGN_W-1:0];
        REG_POLARITY: cfg_q.polarity <= pwdata[0];
        REG_PERIOD:   cfg_q.period   <= pwdata[PWM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GAIN_P:   prdata = APB_DW'(cfg_q.gain_p);
      REG_GAIN_I:   prdata = APB_DW'(cfg_q.gain_i);
      REG_GAIN_D:   prdata = APB_DW'(cfg_q.gain_d);
      REG_BOUND:    prdata = APB_DW'(cfg_q.bound);
      REG_CTS:      prdata = APB_DW'(cfg_q.cts);
      REG_ESIGN:    prdata = APB_DW'(cfg_q.esign);
      REG_POLARITY: prdata = APB_DW'(cfg_q.polarity);
      REG_PERIOD:   prdata = APB_DW'(cfg_q.period);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// ===== sv/motor_speed_pid_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// motor_speed_pid_step
// Fixed-point PID speed step: target and encoder count in, H-bridge direction
// and PWM compare and measured speed out, with a clamped integral.
// ----------------------------------------------------------------------------
// One control tick per input word. The word is taken only in idle; it then
// runs through a sequencer that reuses one 34x25 multiplier (seven products)
// and one divider giving 4 quotient bits per cycle (two 44-bit divisions).
// The next word is taken the cycle after the result is loaded into the output
// register, so no new word is taken while one is still in progress. A result
// waiting in the output register does not block the next word; the new result
// is held in the last step until the output register is free. Integral and
// previous error persist across words and clear on reset.
// Values are signed Q15.16, gains unsigned Q8.16.
module motor_speed_pid_step #(
  parameter int PERIOD_MS = 10
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output      logic                           in_stall_o,
  input  wire logic signed [31:0]             target_speed_i,
  input  wire logic signed [15:0]             encoder_count_i,
  output      logic                           out_valid_o,
  input  wire logic                           out_stall_i,
  output      logic                           drive_a_o,
  output      logic                           drive_b_o,
  output      logic [15:0]                    pwm_compare_o,
  output      logic signed [31:0]             measured_speed_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [mspid_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [mspid_pkg::APB_DW-1:0]   pwdata,
  output      logic [mspid_pkg::APB_DW-1:0]   prdata,
  output      logic                           pready
);
  import mspid_pkg::*;

  localparam logic [MUL_BW-1:0] PERIOD_B = MUL_BW'(PERIOD_MS);
  localparam logic [MUL_BW-1:0] MS_B     = MUL_BW'(MS_PER_S);
  localparam logic [DIV_DW-1:0] PERIOD_D = DIV_DW'(PERIOD_MS);
  localparam logic [DIV_DW-1:0] MS_D     = DIV_DW'(MS_PER_S);

  cfg_t   cfg;
  state_e state_q, state_d;

  logic signed [MUL_AW-1:0] mul_a;
  logic signed [MUL_BW-1:0] mul_b;
  logic signed [MUL_PW-1:0] prod;
  div_req_t                 div_req;
  logic                     div_busy;
  logic [DIV_NW-1:0]        div_quot;

  logic [VAL_W-1:0]   target_q;
  logic [CNT_W-1:0]   count_q;
  logic [VAL_W-1:0]   meas_q;
  logic [VAL_W-1:0]   err_q;
  logic [VAL_W:0]     diff_q;
  logic [VAL_W-1:0]   integ_q;
  logic [VAL_W-1:0]   prev_q;
  logic [VAL_W-1:0]   deriv_q;
  logic [ACC_W-1:0]   acc_q;
  logic [MAG_W-1:0]   mag_q;
  logic               nonneg_q;

  logic               out_valid_q;
  logic               drive_a_q;
  logic [PWM_W-1:0]   pwm_q;
  logic [VAL_W-1:0]   meas_out_q;
  logic               out_free;

  logic [MUL_PW-1:0]  raw_s;
  logic [VAL_W-1:0]   meas_sat;
  logic [VAL_W:0]     err_wide;
  logic [VAL_W-1:0]   err_sat;
  logic [VAL_W-1:0]   err_mag;
  logic [VAL_W:0]     diff_mag;
  logic signed [VAL_W+1:0] inc_s;
  logic signed [VAL_W+1:0] integ_sum;
  logic signed [VAL_W+1:0] bound_s;
  logic signed [VAL_W+1:0] bound_neg;
  logic [VAL_W-1:0]   integ_clamp;
  logic               pos_ovf;
  logic               neg_ovf;
  logic [VAL_W-1:0]   deriv_sat;
  logic [ACC_W-1:0]   prod_x;
  logic [ACC_W-1:0]   acc_mag;
  logic [MAG_W-1:0]   mag_d;
  logic [PWM_W-1:0]   pwm_raw;
  logic [PWM_W-1:0]   pwm_val;

  mspid_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mspid_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  mspid_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .busy_o (div_busy),
    .quot_o (div_quot)
  );

  assign out_free = !out_valid_q || !out_stall_i;

  // datapath arithmetic
  always_comb begin
    if (cfg.esign[1]) begin
      raw_s = -prod;
    end else if (cfg.esign == 2'b00) begin
      raw_s = '0;
    end else begin
      raw_s = prod;
    end
    if ((&raw_s[MUL_PW-1:VAL_W-1]) || !(|raw_s[MUL_PW-1:VAL_W-1])) begin
      meas_sat = raw_s[VAL_W-1:0];
    end else begin
      meas_sat = raw_s[MUL_PW-1] ? VAL_MIN : VAL_MAX;
    end

    err_wide = {target_q[VAL_W-1], target_q} - {meas_q[VAL_W-1], meas_q};
    if (err_wide[VAL_W] != err_wide[VAL_W-1]) begin
      err_sat = err_wide[VAL_W] ? VAL_MIN : VAL_MAX;
    end else begin
      err_sat = err_wide[VAL_W-1:0];
    end

    err_mag  = err_q[VAL_W-1] ? -err_q : err_q;
    diff_mag = diff_q[VAL_W] ? -diff_q : diff_q;

    inc_s     = err_q[VAL_W-1] ? -{2'b00, div_quot[VAL_W-1:0]}
                               : {2'b00, div_quot[VAL_W-1:0]};
    integ_sum = {{2{integ_q[VAL_W-1]}}, integ_q} + inc_s;
    bound_s   = {3'b000, cfg.bound};
    bound_neg = -bound_s;
    if (integ_sum >= bound_s) begin
      integ_clamp = bound_s[VAL_W-1:0];
    end else if (integ_sum <= bound_neg) begin
      integ_clamp = bound_neg[VAL_W-1:0];
    end else begin
      integ_clamp = integ_sum[VAL_W-1:0];
    end

    pos_ovf = |div_quot[DIV_NW-1:VAL_W-1];
    neg_ovf = (|div_quot[DIV_NW-1:VAL_W]) ||
              (div_quot[VAL_W-1] && (|div_quot[VAL_W-2:0]));
    if (diff_q[VAL_W]) begin
      deriv_sat = neg_ovf ? VAL_MIN : -div_quot[VAL_W-1:0];
    end else begin
      deriv_sat = pos_ovf ? VAL_MAX : div_quot[VAL_W-1:0];
    end

    prod_x  = {prod[MUL_PW-1], prod};
    acc_mag = acc_q[ACC_W-1] ? -acc_q : acc_q;
    mag_d   = (|acc_mag[ACC_W-1:VAL_W]) ? MAG_ONE : acc_mag[VAL_W:16];

    pwm_raw = prod[31:16];
    pwm_val = (pwm_raw < PWM_MIN) ? '0 : pwm_raw;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_MEAS_MUL;
      ST_MEAS_MUL: state_d = ST_MEAS;
      ST_MEAS:     state_d = ST_ERROR;
      ST_ERROR:    state_d = ST_INC_MUL;
      ST_INC_MUL:  state_d = ST_INC_DIV;
      ST_INC_DIV:  state_d = ST_INC_WAIT;
      ST_INC_WAIT: if (!div_busy) state_d = ST_INTEG;
      ST_INTEG:    state_d = ST_DIF_MUL;
      ST_DIF_MUL:  state_d = ST_DIF_DIV;
      ST_DIF_DIV:  state_d = ST_DIF_WAIT;
      ST_DIF_WAIT: if (!div_busy) state_d = ST_DERIV;
      ST_DERIV:    state_d = ST_GAIN_P;
      ST_GAIN_P:   state_d = ST_GAIN_I;
      ST_GAIN_I:   state_d = ST_GAIN_D;
      ST_GAIN_D:   state_d = ST_SUM;
      ST_SUM:      state_d = ST_CLAMP;
      ST_CLAMP:    state_d = ST_PWM;
      ST_PWM:      state_d = ST_FIN;
      ST_FIN:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // unit operands
  always_comb begin
    mul_a            = '0;
    mul_b            = '0;
    div_req.start    = 1'b0;
    div_req.dividend = prod[DIV_NW-1:0];
    div_req.divisor  = MS_D;
    case (state_q)
      ST_MEAS_MUL: begin
        mul_a = {{(MUL_AW-CNT_W){count_q[CNT_W-1]}}, count_q};
        mul_b = {1'b0, cfg.cts};
      end
      ST_INC_MUL: begin
        mul_a = {2'b00, err_mag};
        mul_b = PERIOD_B;
      end
      ST_INC_DIV: begin
        div_req.start = 1'b1;
      end
      ST_DIF_MUL: begin
        mul_a = {1'b0, diff_mag};
        mul_b = MS_B;
      end
      ST_DIF_DIV: begin
        div_req.start   = 1'b1;
        div_req.divisor = PERIOD_D;
      end
      ST_GAIN_P: begin
        mul_a = {{2{err_q[VAL_W-1]}}, err_q};
        mul_b = {1'b0, cfg.gain_p};
      end
      ST_GAIN_I: begin
        mul_a = {{2{integ_q[VAL_W-1]}}, integ_q};
        mul_b = {1'b0, cfg.gain_i};
      end
      ST_GAIN_D: begin
        mul_a = {{2{deriv_q[VAL_W-1]}}, deriv_q};
        mul_b = {1'b0, cfg.gain_d};
      end
      ST_PWM, ST_FIN: begin
        mul_a = {{(MUL_AW-MAG_W){1'b0}}, mag_q};
        mul_b = {{(MUL_BW-PWM_W){1'b0}}, cfg.period};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      integ_q     <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_INTEG) begin
        integ_q <= integ_clamp;
      end
      if (state_q == ST_DERIV) begin
        prev_q <= err_q;
      end
      if (state_q == ST_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          target_q <= target_speed_i;
          count_q  <= encoder_count_i;
        end
      end
      ST_MEAS:    meas_q  <= meas_sat;
      ST_ERROR:   err_q   <= err_sat;
      ST_INC_MUL: diff_q  <= {err_q[VAL_W-1], err_q} - {prev_q[VAL_W-1], prev_q};
      ST_DERIV:   deriv_q <= deriv_sat;
      ST_GAIN_I:  acc_q   <= prod_x;
      ST_GAIN_D:  acc_q   <= acc_q + prod_x;
      ST_SUM:     acc_q   <= acc_q + prod_x;
      ST_CLAMP: begin
        mag_q    <= mag_d;
        nonneg_q <= !acc_q[ACC_W-1];
      end
      ST_FIN: begin
        if (out_free) begin
          drive_a_q  <= cfg.polarity ? nonneg_q : !nonneg_q;
          pwm_q      <= pwm_val;
          meas_out_q <= meas_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign drive_a_o        = drive_a_q;
  assign drive_b_o        = !drive_a_q;
  assign pwm_compare_o    = pwm_q;
  assign measured_speed_o = meas_out_q;

endmodule
`default_nettype wire

// ===== bench/motor_speed_pid_step_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// motor_speed_pid_step_test
// Self-checking bench for the motor speed PID step block. A queue of ticks
// feeds a clocked driver, and each accepted word is run through a local
// fixed-point PID model. A clocked monitor compares every result word with
// the oldest predicted bridge command. Settings change over APB only while
// the block is idle: first directed corner cases, then random phases. Both
// handshakes see random gaps and stalls.
// ----------------------------------------------------------------------------
module motor_speed_pid_step_test;
  import mspid_pkg::*;

  localparam int          PERIOD_MS       = 10;
  localparam longint      MS_PER_SEC      = 1000;
  localparam longint      SUM_ONE         = 64'sd1 <<< 32;
  localparam int unsigned MAX_WAIT        = 10;
  localparam int unsigned CYCLE_LIMIT     = 200000;
  localparam int unsigned DRAIN_CYCLES    = 64;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned TICKS_PER_PHASE = 50;
  localparam int unsigned REPORT_LIMIT    = 10;

  typedef enum int {
    SET_ONES,
    SET_ZEROS,
    SET_RANDOM
  } setting_e;

  typedef struct packed {
    logic signed [31:0] target;
    logic signed [15:0] count;
  } pid_tick_t;

  typedef struct packed {
    logic               drive_a;
    logic               drive_b;
    logic [15:0]        pwm;
    logic signed [31:0] speed;
  } bridge_cmd_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic signed [31:0]    target_speed  = '0;
  logic signed [15:0]    encoder_count = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic                  drive_a;
  logic                  drive_b;
  logic [15:0]           pwm_compare;
  logic signed [31:0]    measured_speed;
  logic                  psel          = 1'b0;
  logic                  penable       = 1'b0;
  logic                  pwrite        = 1'b0;
  logic [PADDR_W-1:0]    paddr         = '0;
  logic [APB_DW-1:0]     pwdata        = '0;
  logic [APB_DW-1:0]     prdata;
  logic                  pready;

  pid_tick_t   tick_q[$];
  bridge_cmd_t bridge_cmd_q[$];

  cfg_t cfg_shadow = '{gain_p: RST_GAIN, gain_i: RST_GAIN, gain_d: RST_GAIN,
                       bound: RST_BOUND, cts: RST_CTS, esign: RST_ESIGN,
                       polarity: RST_POL, period: RST_PERIOD};
  logic signed [31:0] integ_acc = '0;
  logic signed [31:0] prev_err  = '0;

  int unsigned in_gap         = 0;
  int unsigned stall_left     = 0;
  bit          in_calm        = 1'b0;
  bit          out_calm       = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  motor_speed_pid_step #(
    .PERIOD_MS(PERIOD_MS)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .target_speed_i  (target_speed),
    .encoder_count_i (encoder_count),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .drive_a_o       (drive_a),
    .drive_b_o       (drive_b),
    .pwm_compare_o   (pwm_compare),
    .measured_speed_o(measured_speed),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic signed [31:0] sat32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return 32'(v);
  endfunction

  function automatic logic signed [31:0] speed_of(input logic signed [15:0] cnt);
    longint raw;
    raw = longint'(cnt) * longint'(cfg_shadow.cts);
    if (cfg_shadow.esign[1]) begin
      raw = -raw;
    end else if (cfg_shadow.esign == '0) begin
      raw = 0;
    end
    return sat32(raw);
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  task automatic pid_tick_predict(input logic signed [31:0] tgt,
                                  input logic signed [15:0] cnt);
    logic signed [31:0] speed;
    logic signed [31:0] err;
    longint             bound;
    longint             integ;
    longint             deriv;
    longint             sum;
    longint             outq;
    longint             mag;
    logic               fwd;
    bridge_cmd_t        cmd;
    speed = speed_of(cnt);
    err   = sat32(longint'(tgt) - longint'(speed));
    bound = longint'(cfg_shadow.bound);
    integ = longint'(integ_acc) + (longint'(err) * PERIOD_MS) / MS_PER_SEC;
    if (integ >= bound) begin
      integ = bound;
    end else if (integ <= -bound) begin
      integ = -bound;
    end
    integ_acc = 32'(integ);
    deriv = longint'(sat32(((longint'(err) - longint'(prev_err)) * MS_PER_SEC) / PERIOD_MS));
    prev_err = err;
    sum = longint'(cfg_shadow.gain_p) * longint'(err)
        + longint'(cfg_shadow.gain_i) * integ
        + longint'(cfg_shadow.gain_d) * deriv;
    if (sum > SUM_ONE) begin
      sum = SUM_ONE;
    end else if (sum < -SUM_ONE) begin
      sum = -SUM_ONE;
    end
    // direction follows the clamped sum, even when the output truncates to 0
    fwd  = (sum >= 0);
    outq = sum / 65536;
    mag  = (outq < 0) ? -outq : outq;
    mag  = (mag * longint'(cfg_shadow.period)) >>> 16;
    if (mag < 10) begin
      mag = 0;
    end
    cmd.drive_a = cfg_shadow.polarity ? fwd : !fwd;
    cmd.drive_b = !cmd.drive_a;
    cmd.pwm     = 16'(mag);
    cmd.speed   = speed;
    bridge_cmd_q.push_back(cmd);
  endtask

  task automatic flag_mismatch(input string what, input longint want_v, input longint got_v);
    if (mismatch_count < REPORT_LIMIT) begin
      $display("%0t %s: expected %0d, got %0d", $time, what, want_v, got_v);
    end
    mismatch_count++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned gap;
    pid_tick_t   tick;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (in_valid && !in_stall) begin
      pid_tick_predict(target_speed, encoder_count);
      if ($urandom_range(0, 15) == 0) begin
        in_calm <= !in_calm;
      end
      gap = draw_wait(in_calm);
      if (gap == 0 && tick_q.size() != 0) begin
        tick = tick_q.pop_front();
        target_speed  <= tick.target;
        encoder_count <= tick.count;
      end else begin
        in_valid <= 1'b0;
        in_gap   <= gap;
      end
    end else if (!in_valid) begin
      if (in_gap != 0) begin
        in_gap <= in_gap - 1;
      end else if (tick_q.size() != 0) begin
        tick = tick_q.pop_front();
        target_speed  <= tick.target;
        encoder_count <= tick.count;
        in_valid      <= 1'b1;
      end
    end
  end

  // monitor: each result word is held off for a drawn number of valid cycles
  always @(posedge clk_i or negedge rst_ni) begin
    bridge_cmd_t want;
    int unsigned hold;
    if (!rst_ni) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if (bridge_cmd_q.size() == 0) begin
        flag_mismatch("result word with none pending", 0, measured_speed);
      end else begin
        want = bridge_cmd_q.pop_front();
        if (drive_a !== want.drive_a) flag_mismatch("drive_a", want.drive_a, drive_a);
        if (drive_b !== want.drive_b) flag_mismatch("drive_b", want.drive_b, drive_b);
        if (pwm_compare !== want.pwm) flag_mismatch("pwm_compare", want.pwm, pwm_compare);
        if (measured_speed !== want.speed) begin
          flag_mismatch("measured_speed", want.speed, measured_speed);
        end
      end
      if ($urandom_range(0, 15) == 0) begin
        out_calm <= !out_calm;
      end
      hold = draw_wait(out_calm);
      out_stall  <= (hold != 0);
      stall_left <= hold;
    end else if (out_valid && stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left != 1);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("motor_speed_pid_step: mismatch");
      $finish;
    end
  end

  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAIN_P:   cfg_shadow.gain_p   = val[GAIN_W-1:0];
      REG_GAIN_I:   cfg_shadow.gain_i   = val[GAIN_W-1:0];
      REG_GAIN_D:   cfg_shadow.gain_d   = val[GAIN_W-1:0];
      REG_BOUND:    cfg_shadow.bound    = val[BOUND_W-1:0];
      REG_CTS:      cfg_shadow.cts      = val[GAIN_W-1:0];
      REG_ESIGN:    cfg_shadow.esign    = val[ESIGN_W-1:0];
      REG_POLARITY: cfg_shadow.polarity = val[0];
      REG_PERIOD:   cfg_shadow.period   = val[PWM_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
  endtask

  task automatic load_settings(input setting_e mode);
    reg_idx_e    idx;
    logic [31:0] v;
    for (int r = REG_GAIN_P; r <= REG_PERIOD; r++) begin
      idx = reg_idx_e'(r);
      if (mode == SET_ONES) begin
        v = '1;
      end else if (mode == SET_ZEROS) begin
        v = '0;
      end else begin
        case (idx)
          REG_BOUND: begin
            case ($urandom_range(0, 3))
              0:       v = '0;
              1:       v = 32'h7FFFFFFF;
              2:       v = $urandom_range(0, 32'h40000);
              default: v = $urandom;
            endcase
          end
          REG_PERIOD: begin
            case ($urandom_range(0, 3))
              0:       v = '0;
              1:       v = 32'hFFFF;
              2:       v = 32'd1000;
              default: v = $urandom;
            endcase
          end
          REG_ESIGN, REG_POLARITY: v = $urandom;
          default: begin
            case ($urandom_range(0, 5))
              0:       v = '0;
              1:       v = 32'hFFFFFF;
              2:       v = $urandom_range(0, 1023);
              3, 4:    v = $urandom_range(32'h1000, 32'h20000);
              default: v = $urandom;
            endcase
          end
        endcase
        v = v | ($urandom & 32'hFF000000);
      end
      cfg_write(idx, v);
    end
  endtask

  task automatic push_tick(input logic signed [31:0] tgt, input logic signed [15:0] cnt);
    tick_q.push_back('{target: tgt, count: cnt});
  endtask

  // mostly ticks that track the measured speed closely, so the loop stays
  // out of saturation; the rest is full-range noise, corners and repeats
  task automatic queue_random_ticks(input int unsigned n);
    pid_tick_t   t;
    pid_tick_t   last;
    int unsigned mode;
    int unsigned mag;
    longint      delta;
    last = '0;
    for (int unsigned k = 0; k < n; k++) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        if (mode < 3) begin
          t.count = 16'($urandom_range(0, 4000)) - 16'd2000;
        end else begin
          t.count = last.count + 16'($urandom_range(0, 20)) - 16'd10;
        end
        mag      = $urandom_range(0, 1 << $urandom_range(0, 20));
        delta    = $urandom_range(0, 1) ? -longint'(mag) : longint'(mag);
        t.target = sat32(longint'(speed_of(t.count)) + delta);
      end else if (mode < 8) begin
        t.target = $urandom;
        t.count  = 16'($urandom);
      end else if (mode == 8) begin
        case ($urandom_range(0, 3))
          0:       t.target = 32'sh80000000;
          1:       t.target = 32'sh7FFFFFFF;
          2:       t.target = '0;
          default: t.target = '1;
        endcase
        case ($urandom_range(0, 3))
          0:       t.count = 16'sh8000;
          1:       t.count = 16'sh7FFF;
          2:       t.count = '0;
          default: t.count = '1;
        endcase
      end else begin
        t = last;
      end
      push_tick(t.target, t.count);
      last = t;
    end
  endtask

  task automatic settle();
    do @(negedge clk_i);
    while (tick_q.size() != 0 || in_valid || bridge_cmd_q.size() != 0);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings, field extremes
    push_tick(32'sh7FFFFFFF, 16'sh7FFF);
    push_tick(32'sh80000000, 16'sh8000);
    push_tick(0, 0);
    push_tick(-1, -1);
    settle();

    // tiny sums: sign decides direction though the output truncates to zero
    cfg_write(REG_GAIN_P, 32'd1);
    cfg_write(REG_GAIN_I, 32'd0);
    cfg_write(REG_GAIN_D, 32'd0);
    push_tick(-1, 0);
    push_tick(1, 0);
    push_tick(0, 0);
    settle();
    cfg_write(REG_POLARITY, 32'd0);
    push_tick(-1, 0);
    push_tick(1, 0);
    settle();

    // encoder sign patterns 10, 11 and 00
    cfg_write(REG_POLARITY, 32'd1);
    cfg_write(REG_GAIN_P, 32'h10000);
    cfg_write(REG_ESIGN, 32'd2);
    push_tick(0, 100);
    settle();
    cfg_write(REG_ESIGN, 32'd3);
    push_tick(0, 100);
    settle();
    cfg_write(REG_ESIGN, 32'd0);
    push_tick(0, 100);
    settle();
    cfg_write(REG_ESIGN, 32'd1);

    // zero period, full scale both ways, compare floor
    cfg_write(REG_PERIOD, 32'd0);
    push_tick(32'sh8000, 0);
    settle();
    cfg_write(REG_PERIOD, 32'hFFFF);
    push_tick(32'sh7FFFFFFF, 0);
    push_tick(32'sh80000000, 0);
    push_tick(600, 0);
    push_tick(9, 0);
    push_tick(11, 0);
    settle();

    // wind the integral up, then tighten the bound under it
    cfg_write(REG_BOUND, 32'h7FFFFFFF);
    cfg_write(REG_GAIN_I, 32'h100);
    push_tick(32'sh7FFFFFFF, 0);
    push_tick(32'sh7FFFFFFF, 0);
    push_tick(32'sh7FFFFFFF, 0);
    settle();
    cfg_write(REG_BOUND, 32'h10000);
    push_tick(0, 0);
    settle();
    cfg_write(REG_BOUND, 32'd0);
    push_tick(0, 0);
    settle();

    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == 0) begin
        load_settings(SET_ONES);
      end else if (ph == 1) begin
        load_settings(SET_ZEROS);
      end else begin
        load_settings(SET_RANDOM);
      end
      queue_random_ticks(TICKS_PER_PHASE);
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (bridge_cmd_q.size() != 0) begin
      flag_mismatch("result words never delivered", 0, bridge_cmd_q.size());
    end
    if (mismatch_count == 0) begin
      $display("motor_speed_pid_step: match");
    end else begin
      $display("motor_speed_pid_step: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/mspid_pkg.sv
sv/mspid_mul.sv
sv/mspid_div.sv
sv/mspid_regs.sv
sv/motor_speed_pid_step.sv
bench/motor_speed_pid_step_test.sv
